// ----- hdl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the trust source selector.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int TRUST_BITS = 16;
    localparam int RAND_BITS  = 16;
    localparam int PEER_BITS  = 6;
    localparam int MODE_BITS  = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_HIGH = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_ANY  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_RESOLVE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic signed [TRUST_BITS-1:0] trust;
        logic                         holds_file;
        logic                         upload_free;
        logic                         last_peer;
        logic [RAND_BITS-1:0]         random_fraction;
    } t_item;

    typedef struct packed {
        logic [PEER_BITS-1:0] chosen_peer;
        logic                 found;
    } t_result;

    typedef struct packed {
        logic update;
        logic clear;
    } t_acc_ctrl;

    typedef struct packed {
        logic load;
        logic step;
    } t_scan_ctrl;

endpackage

// ----- hdl/tss_acc.sv -----
// ----------------------------------------------------------------------------
// tss_acc
// Running extreme, tie bitmap, tie count and peer position of one peer set.
// ----------------------------------------------------------------------------
module tss_acc
    import tss_pkg::*;
#(
    parameter int NUM_PEERS = 64,
    localparam int POS_W = $clog2(NUM_PEERS),
    localparam int CNT_W = $clog2(NUM_PEERS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_acc_ctrl                    i_ctrl,
    input  logic [MODE_BITS-1:0]         i_mode,
    input  logic signed [TRUST_BITS-1:0] i_trust,
    input  logic                         i_eligible,
    output logic [NUM_PEERS-1:0]         o_tie_map,
    output logic [CNT_W-1:0]             o_tie_count
);

    logic signed [TRUST_BITS-1:0] r_ext, n_ext;
    logic [NUM_PEERS-1:0]         r_map, n_map;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic                         do_restart;
    logic                         do_mark;

    // shared compare against the held extreme
    always_comb begin
        do_restart = 1'b0;
        do_mark    = 1'b0;
        if (i_eligible) begin
            unique case (i_mode)
                MODE_HIGH: begin
                    if (r_count == '0 || i_trust > r_ext) do_restart = 1'b1;
                    else if (i_trust == r_ext)           do_mark    = 1'b1;
                end
                MODE_LOW: begin
                    if (r_count == '0 || i_trust < r_ext) do_restart = 1'b1;
                    else if (i_trust == r_ext)           do_mark    = 1'b1;
                end
                default: do_mark = 1'b1;  // uniform, unused code too
            endcase
        end
    end

    always_comb begin
        n_ext   = r_ext;
        n_map   = r_map;
        n_count = r_count;
        n_pos   = r_pos;
        if (i_ctrl.clear) begin
            n_ext   = '0;
            n_map   = '0;
            n_count = '0;
            n_pos   = '0;
        end else if (i_ctrl.update) begin
            if (do_restart) begin
                n_ext        = i_trust;
                n_map        = '0;
                n_map[r_pos] = 1'b1;
                n_count      = CNT_W'(1);
            end else if (do_mark && !r_map[r_pos]) begin
                n_map[r_pos] = 1'b1;
                n_count      = r_count + 1'b1;
            end
            n_pos = (r_pos == POS_W'(NUM_PEERS - 1)) ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext   <= '0;
            r_map   <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_ext   <= n_ext;
            r_map   <= n_map;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    assign o_tie_map   = r_map;
    assign o_tie_count = r_count;

endmodule

// ----- hdl/tss_scan.sv -----
// ----------------------------------------------------------------------------
// tss_scan
// Forms k = floor(r * count / 2^16) and walks the tie bitmap one bit per
// cycle to find the k-th set bit.
// ----------------------------------------------------------------------------
module tss_scan
    import tss_pkg::*;
#(
    parameter int NUM_PEERS = 64,
    localparam int POS_W = $clog2(NUM_PEERS),
    localparam int CNT_W = $clog2(NUM_PEERS + 1)
) (
    input  logic                 i_clk,
    input  t_scan_ctrl           i_ctrl,
    input  logic [RAND_BITS-1:0] i_rand,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [NUM_PEERS-1:0] i_map,
    output logic                 o_hit,
    output logic [POS_W-1:0]     o_idx
);

    localparam int PROD_W = RAND_BITS + CNT_W;

    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  r_k;
    logic [POS_W-1:0]  r_idx;

    assign prod  = PROD_W'(i_rand) * PROD_W'(i_count);
    assign o_hit = i_map[r_idx] && (r_k == '0);
    assign o_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_k   <= prod[RAND_BITS +: CNT_W];
            r_idx <= '0;
        end else if (i_ctrl.step) begin
            if (i_map[r_idx]) r_k <= r_k - 1'b1;
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

// ----- hdl/trust_source_selector.sv -----
// ----------------------------------------------------------------------------
// trust_source_selector
// Picks one source peer per set by highest trust, lowest trust or uniformly
// among eligible peers, breaking ties with a random fraction.
// ----------------------------------------------------------------------------
// Sequencing: each peer is accepted in idle and then updates the accumulator.
//   A last peer goes on to resolve, which ends the set when no peer is marked;
//   else the one-bit-per-cycle bitmap scan walks up to the chosen index.
// Flow: a new peer is taken only while busy is low, after the previous peer is
//   through; the scan runs once per set. The result word strobes for one cycle,
//   the first cycle with busy low again; the receiver cannot stall it.
// Reset: synchronous, clears the set state and sets r_mode to highest.
// ----------------------------------------------------------------------------
module trust_source_selector
    import tss_pkg::*;
#(
    parameter int NUM_PEERS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_res_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MODE_BITS-1:0] i_cfg_data
);

    localparam int POS_W = $clog2(NUM_PEERS);
    localparam int CNT_W = $clog2(NUM_PEERS + 1);

    t_state               r_state, n_state;
    t_item                r_item;
    logic [MODE_BITS-1:0] r_mode;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;

    t_acc_ctrl            acc_ctrl;
    t_scan_ctrl           scan_ctrl;
    logic [NUM_PEERS-1:0] tie_map;
    logic [CNT_W-1:0]     tie_count;
    logic                 scan_hit;
    logic [POS_W-1:0]     scan_idx;
    logic                 accept;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    tss_acc #(.NUM_PEERS(NUM_PEERS)) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (acc_ctrl),
        .i_mode      (r_mode),
        .i_trust     (r_item.trust),
        .i_eligible  (r_item.holds_file & r_item.upload_free),
        .o_tie_map   (tie_map),
        .o_tie_count (tie_count)
    );

    tss_scan #(.NUM_PEERS(NUM_PEERS)) u_scan (
        .i_clk   (i_clk),
        .i_ctrl  (scan_ctrl),
        .i_rand  (r_item.random_fraction),
        .i_count (tie_count),
        .i_map   (tie_map),
        .o_hit   (scan_hit),
        .o_idx   (scan_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (start) n_state = S_UPDATE;
            S_UPDATE:  n_state = r_item.last_peer ? S_RESOLVE : S_IDLE;
            S_RESOLVE: n_state = (tie_count == '0) ? S_IDLE : S_SCAN;
            S_SCAN:    if (scan_hit) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and unit controls
    always_comb begin
        busy               = 1'b1;
        acc_ctrl           = '0;
        scan_ctrl          = '0;
        n_strobe           = 1'b0;
        n_result           = r_result;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_UPDATE: acc_ctrl.update = 1'b1;
            S_RESOLVE: begin
                scan_ctrl.load = 1'b1;
                if (tie_count == '0) begin
                    n_strobe             = 1'b1;
                    n_result.found       = 1'b0;
                    n_result.chosen_peer = '0;
                    acc_ctrl.clear       = 1'b1;
                end
            end
            S_SCAN: begin
                scan_ctrl.step = 1'b1;
                if (scan_hit) begin
                    n_strobe             = 1'b1;
                    n_result.found       = 1'b1;
                    n_result.chosen_peer = PEER_BITS'(scan_idx);
                    acc_ctrl.clear       = 1'b1;
                end
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_HIGH;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_item;
        r_result <= n_result;
    end

    assign o_res_strobe = r_strobe;
    assign o_result     = r_result;

endmodule

// ----- hdl/tss_checker.sv -----
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the trust source selector, bound to the top level.
// ----------------------------------------------------------------------------
module tss_checker
    import tss_pkg::*;
#(
    parameter int NUM_PEERS = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_res_strobe,
    input t_result              o_result
);

    // an accepted word always raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result ends a busy stretch
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy) && !busy)
        else $error("result without preceding work");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held more than one cycle");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_result.found |-> o_result.chosen_peer == '0)
        else $error("chosen peer nonzero with found low");

    a_peer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_result.found |->
            (PEER_BITS + 1)'(o_result.chosen_peer) < (PEER_BITS + 1)'(NUM_PEERS))
        else $error("chosen peer out of range");

endmodule

bind trust_source_selector tss_checker #(.NUM_PEERS(NUM_PEERS)) u_tss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_result     (o_result)
);
